[design/sem_pkg.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude package
// Shared types and constants of the controller and the datapath.
// ----------------------------------------------------------------------------
package sem_pkg;

  localparam int CMP_W = 17;
  localparam int SUM_W = 21;
  localparam int SQ_W  = 20;
  localparam int ROOT_W = 17;
  localparam int ROOT_STEPS = 8;
  localparam int OUT_DATA_W = 40;

  localparam logic [0:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [10:0] WIDTH_RESET  = 11'd640;
  localparam logic [15:0] HEIGHT_RESET = 16'd480;
  localparam logic [7:0]  MAG_SAT      = 8'd255;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_LOAD
  } sem_state_t;

  typedef struct packed {
    logic capture;
    logic step;
    logic square;
    logic sum;
    logic root;
    logic load;
  } sem_cmd_t;

  typedef struct packed {
    logic interior;
    logic out_free;
  } sem_status_t;

endpackage

[design/sem_ctrl.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude controller
// Sequences one pixel through window update, squaring and the square root.
// ----------------------------------------------------------------------------
module sem_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  sem_pkg::sem_status_t status,
  output sem_pkg::sem_cmd_t    cmd,
  output logic                 in_tready,
  output sem_pkg::sem_state_t  state
);

  sem_pkg::sem_state_t state_r;
  sem_pkg::sem_state_t state_nxt;
  logic [2:0] iter_r;
  logic [2:0] iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sem_pkg::ST_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    unique case (state_r)
      sem_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = sem_pkg::ST_CALC;
        end
      end
      sem_pkg::ST_CALC: begin
        state_nxt = status.interior ? sem_pkg::ST_SQUARE : sem_pkg::ST_IDLE;
      end
      sem_pkg::ST_SQUARE: begin
        state_nxt = sem_pkg::ST_SUM;
      end
      sem_pkg::ST_SUM: begin
        state_nxt = sem_pkg::ST_ROOT;
        iter_nxt  = '0;
      end
      sem_pkg::ST_ROOT: begin
        iter_nxt = iter_r + 3'd1;
        if (iter_r == 3'(sem_pkg::ROOT_STEPS - 1)) begin
          state_nxt = sem_pkg::ST_LOAD;
        end
      end
      sem_pkg::ST_LOAD: begin
        if (status.out_free) begin
          state_nxt = sem_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = sem_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      sem_pkg::ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      sem_pkg::ST_CALC:   cmd.step   = 1'b1;
      sem_pkg::ST_SQUARE: cmd.square = 1'b1;
      sem_pkg::ST_SUM:    cmd.sum    = 1'b1;
      sem_pkg::ST_ROOT:   cmd.root   = 1'b1;
      sem_pkg::ST_LOAD:   cmd.load   = status.out_free;
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign state = state_r;

endmodule

[design/sem_datapath.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude datapath
// Line buffers, window, counters, gradient sums, square root and output stage.
// ----------------------------------------------------------------------------
module sem_datapath #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  sem_pkg::sem_cmd_t             cmd,
  output sem_pkg::sem_status_t          status,
  input  logic                          cfg_valid,
  input  logic [0:0]                    cfg_index,
  input  logic [15:0]                   cfg_data,
  input  logic [7:0]                    in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sem_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                          out_tlast
);

  localparam int CNT_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int CW = sem_pkg::CMP_W;

  logic [10:0] cfg_width_r;
  logic [15:0] cfg_height_r;

  logic [7:0] mem_up  [MAX_WIDTH];
  logic [7:0] mem_mid [MAX_WIDTH];
  logic [7:0] rd_up_r;
  logic [7:0] rd_mid_r;

  logic [7:0]       pix_r;
  logic [7:0]       win_r [6];
  logic [CNT_W-1:0] col_r;
  logic [15:0]      row_r;

  logic signed [10:0] gx_r;
  logic signed [10:0] gy_r;
  logic [sem_pkg::SQ_W-1:0] gx2_r;
  logic [sem_pkg::SQ_W-1:0] gy2_r;
  logic [sem_pkg::ROOT_W-1:0] rem_r;
  logic [sem_pkg::ROOT_W-1:0] res_r;
  logic [sem_pkg::ROOT_W-1:0] bit_r;
  logic sat_r;
  logic [9:0]  ccol_r;
  logic [15:0] crow_r;
  logic        last_r;

  logic        out_valid_r;
  logic [7:0]  out_mag_r;
  logic [9:0]  out_col_r;
  logic [15:0] out_row_r;
  logic        out_last_r;

  logic signed [10:0] p00, p01, p02, p10, p12, p20, p21, p22;
  logic signed [10:0] gx_nxt;
  logic signed [10:0] gy_nxt;
  logic [CW-1:0] col_ext, row_ext, w_eff, h_eff, w_ext, h_ext;
  logic last_col, last_row;
  logic [sem_pkg::SUM_W-1:0] sum_nxt;
  logic [sem_pkg::ROOT_W-1:0] trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= sem_pkg::WIDTH_RESET;
      cfg_height_r <= sem_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == sem_pkg::CFG_IDX_WIDTH) begin
        cfg_width_r <= cfg_data[10:0];
      end else begin
        cfg_height_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_up_r  <= mem_up[col_r];
    rd_mid_r <= mem_mid[col_r];
    if (cmd.step) begin
      mem_up[col_r]  <= rd_mid_r;
      mem_mid[col_r] <= pix_r;
    end
  end

  assign p00 = signed'({3'b000, win_r[0]});
  assign p01 = signed'({3'b000, win_r[1]});
  assign p10 = signed'({3'b000, win_r[2]});
  assign p20 = signed'({3'b000, win_r[4]});
  assign p21 = signed'({3'b000, win_r[5]});
  assign p02 = signed'({3'b000, rd_up_r});
  assign p12 = signed'({3'b000, rd_mid_r});
  assign p22 = signed'({3'b000, pix_r});

  assign gx_nxt = (p02 - p00) + 11'sd2 * (p12 - p10) + (p22 - p20);
  assign gy_nxt = (p20 - p00) + 11'sd2 * (p21 - p01) + (p22 - p02);

  assign col_ext = CW'(col_r);
  assign row_ext = CW'(row_r);
  assign w_ext   = CW'(cfg_width_r);
  assign h_ext   = CW'(cfg_height_r);

  always_comb begin
    priority if (w_ext < CW'(3)) begin
      w_eff = CW'(3);
    end else if (w_ext > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    h_eff = (h_ext < CW'(3)) ? CW'(3) : h_ext;
  end

  assign last_col = (col_ext + CW'(1)) >= w_eff;
  assign last_row = (row_ext + CW'(1)) >= h_eff;

  assign status.interior = (col_ext >= CW'(2)) && (row_ext >= CW'(2));
  assign status.out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.step) begin
      win_r[0] <= win_r[1];
      win_r[1] <= rd_up_r;
      win_r[2] <= win_r[3];
      win_r[3] <= rd_mid_r;
      win_r[4] <= win_r[5];
      win_r[5] <= pix_r;
      if (last_col) begin
        col_r <= '0;
        row_r <= last_row ? 16'd0 : row_r + 16'd1;
      end else begin
        col_r <= col_r + CNT_W'(1);
      end
    end
  end

  assign sum_nxt = sem_pkg::SUM_W'(gx2_r) + sem_pkg::SUM_W'(gy2_r);
  assign trial   = res_r + bit_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      pix_r <= in_tdata;
    end
    if (cmd.step) begin
      gx_r   <= gx_nxt;
      gy_r   <= gy_nxt;
      ccol_r <= 10'(col_ext - CW'(1));
      crow_r <= row_r - 16'd1;
      last_r <= last_col && last_row;
    end
    if (cmd.square) begin
      gx2_r <= sem_pkg::SQ_W'(unsigned'(22'(gx_r * gx_r)));
      gy2_r <= sem_pkg::SQ_W'(unsigned'(22'(gy_r * gy_r)));
    end
    if (cmd.sum) begin
      sat_r <= |sum_nxt[sem_pkg::SUM_W-1:16];
      rem_r <= {1'b0, sum_nxt[15:0]};
      res_r <= '0;
      bit_r <= sem_pkg::ROOT_W'(1) << 14;
    end
    if (cmd.root) begin
      if (rem_r >= trial) begin
        rem_r <= rem_r - trial;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_mag_r  <= sat_r ? sem_pkg::MAG_SAT : res_r[7:0];
      out_col_r  <= ccol_r;
      out_row_r  <= crow_r;
      out_last_r <= last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000, out_row_r, out_col_r, out_mag_r};
  assign out_tlast  = out_last_r;

endmodule

[design/sobel_edge_magnitude.sv]
// ----------------------------------------------------------------------------
// Sobel edge magnitude
// Usage:
// The in_ channel carries one 8-bit grayscale pixel per beat in raster order.
// The out_ channel gives one beat per interior pixel: the floor square root of
// gx squared plus gy squared, saturated at 255, with the centre column and
// row; tlast marks the last interior result of a frame. Border pixels give
// no beat. The cfg_ channel writes image width (index 0) and height (1).
// An accepted interior pixel goes through the window, squaring, sum, square
// root and output load steps; its beat turns valid when it is loaded. A border
// pixel returns to idle after the window step. The next pixel is taken in the
// idle state; one pixel at a time. Reset clears the state, counters, window,
// output valid and configuration (width 640, height 480); line buffers and
// other datapath registers are not cleared. If the receiver stalls, the
// result waits in the output register, the next pixel is still taken and
// worked on, and its result is held until the output register is free.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] pixel_value.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [7:0] edge_magnitude, [17:8] centre_column,
                                   // [33:18] centre_row, [39:34] zero.
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  sem_pkg::sem_cmd_t    cmd;
  sem_pkg::sem_status_t status;
  sem_pkg::sem_state_t  state;

  assign cfg_ready = 1'b1;

  sem_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .status    (status),
    .cmd       (cmd),
    .in_tready (in_tready),
    .state     (state)
  );

  sem_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTHESIS
  a_one_pixel_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("A second pixel was taken while one was in work.");

  a_load_needs_free_output: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> status.out_free)
    else $error("A result overwrote one that was not yet taken.");

  a_load_follows_root: assert property (@(posedge clk) disable iff (!rst_n)
    state == sem_pkg::ST_LOAD |->
      $past(state) == sem_pkg::ST_ROOT || $past(state) == sem_pkg::ST_LOAD)
    else $error("A result was loaded without a finished square root.");
`endif

endmodule
